// ===== rtl/eba_pkg.sv =====
// ---------------------------------------------------------------------------
// eba_pkg: shared types and constants of the eight-bit CPU ALU
// Operation codes, data widths and positions of the bits in the flag byte.
// ---------------------------------------------------------------------------
package eba_pkg;

	localparam int DATA_W = 8;
	localparam int OP_W   = 5;
	localparam int IDX_W  = 3;

	// Positions of the flags in the incoming flag byte.
	localparam int FLAG_Z = 7;
	localparam int FLAG_N = 6;
	localparam int FLAG_H = 5;
	localparam int FLAG_C = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_AND  = 5'd2,
		OP_OR   = 5'd3,
		OP_XOR  = 5'd4,
		OP_NOT  = 5'd5,
		OP_DAA  = 5'd6,
		OP_RLC  = 5'd7,
		OP_RRC  = 5'd8,
		OP_RL   = 5'd9,
		OP_RR   = 5'd10,
		OP_SLA  = 5'd11,
		OP_SRA  = 5'd12,
		OP_SRL  = 5'd13,
		OP_SWAP = 5'd14,
		OP_BIT  = 5'd15,
		OP_RES  = 5'd16,
		OP_SET  = 5'd17
	} op_t;

endpackage

// ===== rtl/eight_bit_cpu_alu.sv =====
// ---------------------------------------------------------------------------
// eight_bit_cpu_alu: eight-bit ALU of a handheld-console CPU
// Arithmetic, logic, decimal adjust, rotates, shifts and bit operations.
// ---------------------------------------------------------------------------
// A request passes through the input register and then the result register
// before done is high.
// Throughput: one request per cycle; busy is never raised, so start may be held.
// Reset: arst_n clears the valid bits of both stages at once; the payload
// registers are not reset. The receiver cannot stall, so nothing waits.
module eight_bit_cpu_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        start,
	output logic                        busy,
	input  logic [eba_pkg::OP_W-1:0]    req_type,
	input  logic [eba_pkg::DATA_W-1:0]  operand_a,
	input  logic [eba_pkg::DATA_W-1:0]  operand_b,
	input  logic [eba_pkg::IDX_W-1:0]   bit_index,
	input  logic [eba_pkg::DATA_W-1:0]  flags_in,
	// result side
	output logic                        done,
	output logic [eba_pkg::DATA_W-1:0]  result,
	output logic                        half_carry,
	output logic                        carry_out,
	output logic                        zero_flag,
	output logic                        bit_value
);
	import eba_pkg::*;

	// -----------------------------------------------------------------
	// Stage 1: input register. A transfer is taken whenever start is high;
	// every operation completes in one pass, so the block never holds off.
	// -----------------------------------------------------------------
	logic              valid_s1;
	op_t               op_s1;
	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [DATA_W-1:0] f_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1  <= op_t'(req_type);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
			idx_s1 <= bit_index;
			f_s1   <= flags_in;
		end
	end

	// -----------------------------------------------------------------
	// Combinational datapath between the two registers.
	// -----------------------------------------------------------------
	logic              cin, nin, hin;
	logic [DATA_W:0]   sum9;      // a + b + carry, with carry out in the top bit
	logic [4:0]        sum_lo;    // low nibble sum for the half carry
	logic [DATA_W:0]   subtr9;    // b + carry, the full subtrahend
	logic [4:0]        subtr_lo;
	logic [DATA_W-1:0] mask;      // one-hot mask of the selected bit
	logic              daa_lo;    // low-nibble correction needed after an add
	logic [DATA_W:0]   daa_t1;
	logic              daa_hi;    // high-nibble correction needed after an add
	logic [DATA_W:0]   daa_t2;
	logic [DATA_W-1:0] daa_sub;   // corrected value after a subtraction

	logic [DATA_W-1:0] r_d;
	logic              h_d, c_d, z_d, bv_d;

	always_comb begin
		cin = f_s1[FLAG_C];
		nin = f_s1[FLAG_N];
		hin = f_s1[FLAG_H];

		sum9     = {1'b0, a_s1} + {1'b0, b_s1} + {{DATA_W{1'b0}}, cin};
		sum_lo   = {1'b0, a_s1[3:0]} + {1'b0, b_s1[3:0]} + {4'd0, cin};
		subtr9   = {1'b0, b_s1} + {{DATA_W{1'b0}}, cin};
		subtr_lo = {1'b0, b_s1[3:0]} + {4'd0, cin};

		mask = {{(DATA_W-1){1'b0}}, 1'b1} << idx_s1;

		// Decimal adjust after an addition: the two corrections can push the
		// sum past eight bits, and that bit becomes the carry.
		daa_lo = hin || (a_s1[3:0] > 4'd9);
		daa_t1 = {1'b0, a_s1} + (daa_lo ? 9'h006 : 9'h000);
		daa_hi = cin || (daa_t1 > 9'h09F);
		daa_t2 = daa_t1 + (daa_hi ? 9'h060 : 9'h000);
		// After a subtraction the carry never changes; only the byte is fixed.
		daa_sub = a_s1 - (hin ? 8'h06 : 8'h00) - (cin ? 8'h60 : 8'h00);

		r_d  = '0;
		h_d  = 1'b0;
		c_d  = 1'b0;
		z_d  = 1'b0;
		bv_d = 1'b0;

		unique case (op_s1)
			OP_ADD: begin
				r_d = sum9[DATA_W-1:0];
				h_d = sum_lo[4];
				c_d = sum9[DATA_W];
			end
			OP_SUB: begin
				r_d = a_s1 - b_s1 - {{(DATA_W-1){1'b0}}, cin};
				h_d = {1'b0, a_s1[3:0]} < subtr_lo;
				c_d = {1'b0, a_s1} < subtr9;
			end
			OP_AND: r_d = a_s1 & b_s1;
			OP_OR:  r_d = a_s1 | b_s1;
			OP_XOR: r_d = a_s1 ^ b_s1;
			OP_NOT: r_d = ~a_s1;
			OP_DAA: begin
				if (nin) begin
					r_d = daa_sub;
					c_d = cin;
				end else begin
					r_d = daa_t2[DATA_W-1:0];
					c_d = cin | daa_t2[DATA_W];
				end
				z_d = (r_d == '0);
			end
			OP_RLC: begin
				c_d = a_s1[DATA_W-1];
				r_d = {a_s1[DATA_W-2:0], a_s1[DATA_W-1]};
			end
			OP_RRC: begin
				c_d = a_s1[0];
				r_d = {a_s1[0], a_s1[DATA_W-1:1]};
			end
			OP_RL: begin
				c_d = a_s1[DATA_W-1];
				r_d = {a_s1[DATA_W-2:0], cin};
			end
			OP_RR: begin
				c_d = a_s1[0];
				r_d = {cin, a_s1[DATA_W-1:1]};
			end
			OP_SLA: begin
				c_d = a_s1[DATA_W-1];
				r_d = {a_s1[DATA_W-2:0], 1'b0};
			end
			OP_SRA: begin
				c_d = a_s1[0];
				r_d = {a_s1[DATA_W-1], a_s1[DATA_W-1:1]};
			end
			OP_SRL: begin
				c_d = a_s1[0];
				r_d = {1'b0, a_s1[DATA_W-1:1]};
			end
			OP_SWAP: r_d = {a_s1[3:0], a_s1[7:4]};
			OP_BIT: begin
				r_d  = a_s1;
				bv_d = a_s1[idx_s1];
			end
			OP_RES: r_d = a_s1 & ~mask;
			OP_SET: r_d = a_s1 | mask;
			default: begin
				// Selector codes without an operation give all zeros.
				r_d = '0;
			end
		endcase
	end

	// -----------------------------------------------------------------
	// Stage 2: result register. done marks the single cycle in which the
	// result transfer is presented.
	// -----------------------------------------------------------------
	logic              done_s2;
	logic [DATA_W-1:0] result_s2;
	logic              half_carry_s2, carry_out_s2, zero_flag_s2, bit_value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2     <= r_d;
			half_carry_s2 <= h_d;
			carry_out_s2  <= c_d;
			zero_flag_s2  <= z_d;
			bit_value_s2  <= bv_d;
		end
	end

	assign done       = done_s2;
	assign result     = result_s2;
	assign half_carry = half_carry_s2;
	assign carry_out  = carry_out_s2;
	assign zero_flag  = zero_flag_s2;
	assign bit_value  = bit_value_s2;

`ifndef SYNTH
	// Every accepted request yields its result through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request transfer not followed by a result two cycles later");

	// A result appears only for a request taken through both registers.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result transfer without a matching request");

	// Half carry is only produced by addition and subtraction.
	a_half_carry_src: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && h_d) |-> (op_s1 == OP_ADD || op_s1 == OP_SUB))
		else $error("half carry raised by an operation other than add or sub");

	// The zero flag and the tested bit belong to decimal adjust and bit test.
	a_flag_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> (!zero_flag || $past(op_s1 == OP_DAA))
			&& (!bit_value || $past(op_s1 == OP_BIT)))
		else $error("zero flag or tested bit raised by the wrong operation");
`endif

endmodule
